FILE: rtl/core/pwsp_pkg.sv
// shared types and codes for the protobuf wire stream parser
// no dependencies; imported by every module of the block
package pwsp_pkg;

	// result kinds carried on the output tuser
	typedef enum logic [2:0] {
		KIND_SCALAR    = 3'd0,
		KIND_LEN_HDR   = 3'd1,
		KIND_PAYLOAD   = 3'd2,
		KIND_BAD_WIRE  = 3'd3,
		KIND_TRUNCATED = 3'd4
	} kind_t;

	// wire type codes
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	// decoder phase, one-hot
	typedef enum logic [5:0] {
		PH_KEY     = 6'b000001,
		PH_VARINT  = 6'b000010,
		PH_FIXED   = 6'b000100,
		PH_LENGTH  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_STOPPED = 6'b100000
	} phase_t;

	// shift limits of the accumulator
	localparam logic [6:0] SHIFT_WORD = 7'd64;
	localparam logic [6:0] SHIFT_SAT  = 7'd70;
	localparam logic [6:0] VAR_STEP   = 7'd7;
	localparam logic [6:0] FIX_STEP   = 7'd8;
	localparam logic [30:0] FIX64_BYTES = 31'd8;
	localparam logic [30:0] FIX32_BYTES = 31'd4;

	// one input item held in the input stage
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	// one result item
	typedef struct packed {
		kind_t              kind;
		logic [28:0]        field_number;
		logic [2:0]         wire_type;
		logic [63:0]        value;
		logic signed [63:0] zigzag_value;
		logic               payload_last;
	} result_t;

endpackage

FILE: rtl/core/pwsp_in_reg.sv
// input stage of the protobuf wire stream parser: one item register
// depends on pwsp_pkg
module pwsp_in_reg import pwsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     item_valid,
	output in_item_t item
);

	logic     valid_s1;
	in_item_t item_s1;

	// stage is free when empty or handing its item on this cycle
	assign in_ready   = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/core/pwsp_decoder.sv
// byte-wise decoder state and next-state logic of the protobuf wire stream parser
// depends on pwsp_pkg
module pwsp_decoder import pwsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t item,
	output logic     res_valid,
	output result_t  res
);

	phase_t      phase_q, phase_n;
	logic [63:0] acc_q, acc_n;
	logic [6:0]  shift_q, shift_n;
	logic [28:0] field_q, field_n;
	logic [2:0]  wire_q, wire_n;
	logic [30:0] left_q, left_n;

	logic [63:0] acc7, acc8;
	logic [6:0]  shift7, shift8;
	logic [30:0] left_dec;
	logic        group_end;
	logic [7:0]  b;

	assign b         = item.data_byte;
	assign group_end = !b[7];

	// seven-bit varint absorb and eight-bit fixed absorb
	assign acc7   = (shift_q < SHIFT_WORD) ?
		(acc_q | ({57'd0, b[6:0]} << shift_q[5:0])) : acc_q;
	assign shift7 = (shift_q < SHIFT_SAT) ? shift_q + VAR_STEP : shift_q;
	assign acc8   = (shift_q < SHIFT_WORD) ?
		(acc_q | ({56'd0, b} << shift_q[5:0])) : acc_q;
	assign shift8 = (shift_q < SHIFT_WORD) ? shift_q + FIX_STEP : shift_q;
	assign left_dec = (left_q != 31'd0) ? left_q - 31'd1 : left_q;

	// next state and result
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		shift_n   = shift_q;
		field_n   = field_q;
		wire_n    = wire_q;
		left_n    = left_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_KEY: begin
				acc_n   = acc7;
				shift_n = shift7;
				if (group_end) begin
					field_n = acc7[31:3];
					wire_n  = acc7[2:0];
					acc_n   = '0;
					shift_n = '0;
					unique case (acc7[2:0])
						WT_VARINT: phase_n = PH_VARINT;
						WT_FIXED64: begin
							phase_n = PH_FIXED;
							left_n  = FIX64_BYTES;
						end
						WT_FIXED32: begin
							phase_n = PH_FIXED;
							left_n  = FIX32_BYTES;
						end
						WT_LEN: phase_n = PH_LENGTH;
						default: begin
							res_valid        = 1'b1;
							res.kind         = KIND_BAD_WIRE;
							res.field_number = acc7[31:3];
							res.wire_type    = acc7[2:0];
							phase_n          = PH_STOPPED;
						end
					endcase
				end
			end
			PH_VARINT: begin
				acc_n   = acc7;
				shift_n = shift7;
				if (group_end) begin
					res_valid        = 1'b1;
					res.kind         = KIND_SCALAR;
					res.field_number = field_q;
					res.wire_type    = wire_q;
					res.value        = acc7;
					res.zigzag_value = {1'b0, acc7[63:1]} ^ {64{acc7[0]}};
					acc_n            = '0;
					shift_n          = '0;
					phase_n          = PH_KEY;
				end
			end
			PH_FIXED: begin
				acc_n   = acc8;
				shift_n = shift8;
				left_n  = left_dec;
				if (left_dec == 31'd0) begin
					res_valid        = 1'b1;
					res.kind         = KIND_SCALAR;
					res.field_number = field_q;
					res.wire_type    = wire_q;
					res.value        = acc8;
					acc_n            = '0;
					shift_n          = '0;
					phase_n          = PH_KEY;
				end
			end
			PH_LENGTH: begin
				acc_n   = acc7;
				shift_n = shift7;
				if (group_end) begin
					acc_n   = '0;
					shift_n = '0;
					if (acc7[63:31] != 33'd0) begin
						phase_n = PH_STOPPED;
					end else begin
						res_valid        = 1'b1;
						res.kind         = KIND_LEN_HDR;
						res.field_number = field_q;
						res.wire_type    = wire_q;
						res.value        = acc7;
						left_n           = acc7[30:0];
						phase_n          = (acc7[30:0] != 31'd0) ? PH_PAYLOAD : PH_KEY;
					end
				end
			end
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.field_number = field_q;
				res.wire_type    = wire_q;
				res.value        = {56'd0, b};
				res.payload_last = (left_q <= 31'd1);
				left_n           = left_dec;
				if (left_q <= 31'd1) begin
					left_n  = '0;
					phase_n = PH_KEY;
				end
			end
			PH_STOPPED: begin
				phase_n = PH_STOPPED;
			end
			default: begin
				phase_n = PH_KEY;
			end
		endcase

		// frame end: flag an open item as truncated, then return to reset
		if (item.frame_end) begin
			if (phase_n != PH_STOPPED && (phase_n != PH_KEY || shift_n != 7'd0)) begin
				res_valid        = 1'b1;
				res              = '0;
				res.kind         = KIND_TRUNCATED;
				res.field_number = (phase_n == PH_KEY) ? 29'd0 : field_n;
				res.wire_type    = (phase_n == PH_KEY) ? 3'd0 : wire_n;
			end
			phase_n = PH_KEY;
			acc_n   = '0;
			shift_n = '0;
			field_n = '0;
			wire_n  = '0;
			left_n  = '0;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_q   <= '0;
			shift_q <= '0;
			field_q <= '0;
			wire_q  <= '0;
			left_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			shift_q <= shift_n;
			field_q <= field_n;
			wire_q  <= wire_n;
			left_q  <= left_n;
		end
	end

	// shift never passes its saturation point
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q <= SHIFT_SAT)
		else $error("accumulator shift out of range");

	// a payload phase always has bytes to go
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != 31'd0))
		else $error("payload phase with no bytes left");

	// a fixed field counts down from at most eight bytes
	a_fixed_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIXED) |-> (left_q != 31'd0 && left_q <= FIX64_BYTES))
		else $error("fixed field byte count out of range");

	// the end of a frame leaves the decoder awaiting a fresh key
	a_frame_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.frame_end) |=> (phase_q == PH_KEY && shift_q == 7'd0))
		else $error("decoder not reset after frame end");

endmodule

FILE: rtl/core/protobuf_wire_stream_parser_top.sv
// top level of the protobuf wire stream parser: input stage, decoder, result register
// depends on pwsp_pkg, pwsp_in_reg and pwsp_decoder
//
// Usage:
//  The slave channel takes the serialized message one byte per item; s_tlast
//  marks the final byte of the message buffer. The master channel gives at
//  most one result item per input byte: a scalar field, a length header, a
//  payload byte, a bad wire type report or a truncation report. m_tuser holds
//  the result kind and m_tlast flags the last payload byte of a
//  length-delimited field.
//  Path: a byte accepted into the input stage is decoded from there and its
//  result is registered in the output register; a stall on the master channel holds both.
//  Throughput: one byte per cycle while the receiver takes results, set by the
//  combinational varint shift and phase update in the decoder; bytes that give
//  no result are consumed at that same rate.
//  Reset clears the input stage, the result valid flag and the decoder, which
//  then awaits a key varint. When the receiver stalls, the result is held
//  in the output register, one more byte waits in the input stage, and
//  s_tready then falls until the result is taken.
module protobuf_wire_stream_parser_top import pwsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte[7:0]
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,  // field_number[28:0], wire_type[31:29],
	                               // value[95:32], zigzag_value[159:96]
	output logic [2:0]   m_tuser,  // kind[2:0]
	output logic         m_tlast
);

	in_item_t in_item;
	in_item_t item;
	logic     item_valid;
	logic     advance;
	logic     res_valid;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	assign in_item.data_byte = s_tdata;
	assign in_item.frame_end = s_tlast;

	// the held byte is decoded once the result register can take its result
	assign advance = item_valid && (!out_valid_q || m_tready);

	pwsp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	pwsp_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	// master channel packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.zigzag_value, out_q.value, out_q.wire_type, out_q.field_number};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.payload_last;

endmodule

FILE: tb/wire_decode_checker.sv
`timescale 1ns / 1ps
// checker for the protobuf wire stream parser: decodes every accepted byte on its own
// and compares each result item with the oldest decoded field still due
// depends on pwsp_pkg
module wire_decode_checker import pwsp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte[7:0]
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [159:0] m_tdata,   // field_number[28:0], wire_type[31:29],
	                                // value[95:32], zigzag_value[159:96]
	input  logic [2:0]   m_tuser,   // kind[2:0]
	input  logic         m_tlast,
	output int           mismatches,
	output int           results_due,
	output int           results_checked
);

	localparam int REPORT_LIMIT = 10;

	// own copy of the decoder state
	phase_t      phase;
	logic [63:0] acc;
	logic [6:0]  shift;
	logic [28:0] cur_field;
	logic [2:0]  cur_wire;
	logic [30:0] bytes_left;

	result_t fields_due[$];
	int      errors;
	int      checked;

	initial begin
		errors = 0;
		checked = 0;
	end

	task automatic clear_acc();
		acc = '0;
		shift = '0;
	endtask

	task automatic restart();
		phase = PH_KEY;
		clear_acc();
		cur_field = '0;
		cur_wire = '0;
		bytes_left = '0;
	endtask

	// seven payload bits of a varint byte, bits past 64 are dropped
	task automatic absorb7(input logic [7:0] b);
		if (shift < SHIFT_WORD)
			acc |= {57'd0, b[6:0]} << shift;
		if (shift < SHIFT_SAT)
			shift += VAR_STEP;
	endtask

	// one byte through the decoder, queues the result item it gives if any
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		result_t     r;
		logic        emit;
		logic        is_last;
		logic [63:0] len;
		r = '0;
		emit = 1'b0;
		case (phase)
			PH_KEY: begin
				absorb7(b);
				if (!b[7]) begin
					cur_field = acc[31:3];
					cur_wire = acc[2:0];
					clear_acc();
					case (cur_wire)
						WT_VARINT: phase = PH_VARINT;
						WT_FIXED64: begin
							phase = PH_FIXED;
							bytes_left = FIX64_BYTES;
						end
						WT_FIXED32: begin
							phase = PH_FIXED;
							bytes_left = FIX32_BYTES;
						end
						WT_LEN: phase = PH_LENGTH;
						default: begin
							r.kind = KIND_BAD_WIRE;
							r.field_number = cur_field;
							r.wire_type = cur_wire;
							emit = 1'b1;
							phase = PH_STOPPED;
						end
					endcase
				end
			end
			PH_VARINT: begin
				absorb7(b);
				if (!b[7]) begin
					r.kind = KIND_SCALAR;
					r.field_number = cur_field;
					r.wire_type = cur_wire;
					r.value = acc;
					r.zigzag_value = {1'b0, acc[63:1]} ^ {64{acc[0]}};
					emit = 1'b1;
					clear_acc();
					phase = PH_KEY;
				end
			end
			PH_FIXED: begin
				// little-endian bytes
				if (shift < SHIFT_WORD) begin
					acc |= {56'd0, b} << shift;
					shift += FIX_STEP;
				end
				if (bytes_left != 0)
					bytes_left--;
				if (bytes_left == 0) begin
					r.kind = KIND_SCALAR;
					r.field_number = cur_field;
					r.wire_type = cur_wire;
					r.value = acc;
					emit = 1'b1;
					clear_acc();
					phase = PH_KEY;
				end
			end
			PH_LENGTH: begin
				absorb7(b);
				if (!b[7]) begin
					len = acc;
					clear_acc();
					// oversize length stops the frame silently
					if (len[63:31] != '0) begin
						phase = PH_STOPPED;
					end else begin
						r.kind = KIND_LEN_HDR;
						r.field_number = cur_field;
						r.wire_type = cur_wire;
						r.value = len;
						emit = 1'b1;
						bytes_left = len[30:0];
						phase = (bytes_left != 0) ? PH_PAYLOAD : PH_KEY;
					end
				end
			end
			PH_PAYLOAD: begin
				is_last = bytes_left <= 1;
				r.kind = KIND_PAYLOAD;
				r.field_number = cur_field;
				r.wire_type = cur_wire;
				r.value = {56'd0, b};
				r.payload_last = is_last;
				emit = 1'b1;
				if (bytes_left != 0)
					bytes_left--;
				if (is_last) begin
					bytes_left = '0;
					phase = PH_KEY;
				end
			end
			default: ;
		endcase

		// frame closing with an item still open
		if (fin) begin
			if (phase != PH_STOPPED && (phase != PH_KEY || shift != 0)) begin
				r = '0;
				r.kind = KIND_TRUNCATED;
				if (phase != PH_KEY) begin
					r.field_number = cur_field;
					r.wire_type = cur_wire;
				end
				emit = 1'b1;
			end
			restart();
		end

		if (emit)
			fields_due.push_back(r);
	endtask

	// compare one result item with the oldest one due
	task automatic check_result();
		result_t got;
		result_t want;
		got.kind = kind_t'(m_tuser);
		got.field_number = m_tdata[28:0];
		got.wire_type = m_tdata[31:29];
		got.value = m_tdata[95:32];
		got.zigzag_value = m_tdata[159:96];
		got.payload_last = m_tlast;
		checked++;
		if (fields_due.size() == 0) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: result item with none due: kind %0d field %0d wire %0d value %h",
					$time, got.kind, got.field_number, got.wire_type, got.value);
		end else begin
			want = fields_due.pop_front();
			if (got.kind != want.kind || got.field_number != want.field_number ||
					got.wire_type != want.wire_type || got.value != want.value ||
					got.zigzag_value != want.zigzag_value ||
					got.payload_last != want.payload_last) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0t: result item mismatch", $time);
					$display("  expected kind %0d field %0d wire %0d value %h zigzag %h last %b",
						want.kind, want.field_number, want.wire_type, want.value,
						want.zigzag_value, want.payload_last);
					$display("  actual   kind %0d field %0d wire %0d value %h zigzag %h last %b",
						got.kind, got.field_number, got.wire_type, got.value,
						got.zigzag_value, got.payload_last);
				end
			end
		end
	endtask

	// results are compared before the new byte is decoded
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart();
			fields_due.delete();
			results_due <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			results_due <= fields_due.size();
		end
		mismatches <= errors;
		results_checked <= checked;
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// top of the protobuf wire stream parser testbench: clock, reset, message stimulus and verdict
// depends on pwsp_pkg, protobuf_wire_stream_parser_top and wire_decode_checker
module testbench;
	import pwsp_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 320;
	localparam int TAIL_BYTES   = 60;

	// wire types the block does not know
	localparam logic [2:0] WT_GROUP_START = 3'd3;
	localparam logic [2:0] WT_GROUP_END   = 3'd4;
	localparam logic [2:0] WT_RESERVED6   = 3'd6;
	localparam logic [2:0] WT_RESERVED7   = 3'd7;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // data_byte[7:0]
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;   // field_number[28:0], wire_type[31:29],
	                         // value[95:32], zigzag_value[159:96]
	logic [2:0]   m_tuser;   // kind[2:0]
	logic         m_tlast;

	int mismatches;
	int results_due;
	int results_checked;

	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit hold_request = 1'b0;

	int         bytes_fed = 0;
	int         frames_sent = 0;
	int         quiet_cycles = 0;
	logic [7:0] msg_bytes[$];

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	protobuf_wire_stream_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	wire_decode_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.results_due     (results_due),
		.results_checked (results_checked)
	);

	// message encoding into msg_bytes
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	function automatic void put_varint(input logic [63:0] v);
		do begin
			msg_bytes.push_back({v > 64'd127, v[6:0]});
			v = v >> 7;
		end while (v != 0);
	endfunction

	// now and then a key with junk above bit 31
	function automatic void put_key(input logic [28:0] f, input logic [2:0] wt);
		logic [31:0] upper;
		upper = ($urandom_range(0, 11) == 0) ? $urandom : 32'd0;
		put_varint({upper, f, wt});
	endfunction

	function automatic void put_fixed(input int n, input logic [63:0] v);
		for (int i = 0; i < n; i++)
			msg_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_payload(input int n);
		repeat (n) msg_bytes.push_back(8'($urandom));
	endfunction

	// varint longer than ten bytes, top bits lost
	function automatic void put_long_varint(input int n);
		logic [7:0] b;
		repeat (n - 1) begin
			b = 8'($urandom);
			b[7] = 1'b1;
			msg_bytes.push_back(b);
		end
		msg_bytes.push_back(8'($urandom_range(0, 127)));
	endfunction

	function automatic void put_random_field();
		logic [28:0] f;
		int          len;
		case ($urandom_range(0, 9))
			0: f = '1;
			1: f = 29'($urandom);
			default: f = 29'($urandom_range(1, 40));
		endcase
		case ($urandom_range(0, 3))
			0: begin
				put_key(f, WT_VARINT);
				if ($urandom_range(0, 9) == 0)
					put_long_varint($urandom_range(11, 14));
				else
					put_varint(rand64());
			end
			1: begin
				put_key(f, WT_FIXED32);
				put_fixed(4, rand64());
			end
			2: begin
				put_key(f, WT_FIXED64);
				put_fixed(8, {$urandom, $urandom});
			end
			default: begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
				put_key(f, WT_LEN);
				put_varint(64'(len));
				put_payload(len);
			end
		endcase
	endfunction

	// mostly well-formed messages, some noise, stops and cut-off frames
	function automatic void build_random_frame();
		logic [28:0] f;
		logic [2:0]  wt;
		int          cut;
		f = 29'($urandom_range(1, 40));
		case ($urandom_range(0, 19))
			0: begin
				repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
			end
			1: begin
				case ($urandom_range(0, 3))
					0: wt = WT_GROUP_START;
					1: wt = WT_GROUP_END;
					2: wt = WT_RESERVED6;
					default: wt = WT_RESERVED7;
				endcase
				repeat ($urandom_range(0, 2)) put_random_field();
				put_key(f, wt);
				put_payload($urandom_range(0, 5));
			end
			2: begin
				repeat ($urandom_range(0, 2)) put_random_field();
				put_key(f, WT_LEN);
				put_varint(64'h8000_0000 | rand64());
				put_payload($urandom_range(0, 5));
			end
			3, 4, 5: begin
				repeat ($urandom_range(1, 3)) put_random_field();
				if (msg_bytes.size() > 1) begin
					cut = $urandom_range(1, msg_bytes.size() - 1);
					repeat (cut) void'(msg_bytes.pop_back());
				end
			end
			default: repeat ($urandom_range(1, 4)) put_random_field();
		endcase
	endfunction

	// one byte across the slave channel, with an occasional gap before it
	task automatic send_byte(input logic [7:0] d, input logic fin);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_fed++;
	endtask

	task automatic send_frame();
		int n;
		n = msg_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		msg_bytes.delete();
		frames_sent++;
	endtask

	// sender pauses until every result item has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random stall bursts, and one long hold on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no item moved for %0d cycles", STALL_LIMIT);
				$display("FAIL protobuf_wire_stream_parser_top");
				$finish;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int stop_at;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every known wire type, field number and value extremes, zigzag of an odd value
		put_key(29'd1, WT_VARINT);
		put_varint(64'd0);
		put_key('1, WT_VARINT);
		put_varint('1);
		put_key(29'd2, WT_VARINT);
		put_varint(64'd1);
		put_key(29'd3, WT_FIXED32);
		put_fixed(4, 64'hFFFF_FFFF);
		put_key(29'd4, WT_FIXED64);
		put_fixed(8, '1);
		put_key(29'd5, WT_LEN);
		put_varint(64'd2);
		put_payload(2);
		// zero length ends on the header
		put_key(29'd6, WT_LEN);
		put_varint(64'd0);
		send_frame();

		// over-long varint
		put_key(29'd7, WT_VARINT);
		put_long_varint(12);
		send_frame();

		// unknown wire type, then ignored bytes
		put_key(29'd8, WT_GROUP_START);
		put_payload(2);
		send_frame();

		// length of exactly 2^31
		put_key(29'd9, WT_LEN);
		put_varint(64'h8000_0000);
		put_payload(1);
		send_frame();

		// frames cut inside a key, after a key, inside a payload, inside a varint
		msg_bytes.push_back(8'h88);
		send_frame();
		put_key(29'd10, WT_FIXED64);
		send_frame();
		put_key(29'd11, WT_LEN);
		put_varint(64'd3);
		put_payload(1);
		send_frame();
		put_key(29'd12, WT_VARINT);
		msg_bytes.push_back(8'h80);
		send_frame();
		drain();

		// receiver holds off while a long payload keeps coming
		hold_request = 1'b1;
		tx_gaps = 1'b0;
		put_key(29'd13, WT_LEN);
		put_varint(64'd24);
		put_payload(24);
		send_frame();
		tx_gaps = 1'b1;
		drain();

		// random messages with gaps on both sides
		stop_at = bytes_fed + RANDOM_BYTES;
		while (bytes_fed < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				tx_gaps = !tx_gaps;
			build_random_frame();
			send_frame();
		end
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		drain();

		// last part at full rate
		stop_at = bytes_fed + TAIL_BYTES;
		while (bytes_fed < stop_at) begin
			build_random_frame();
			send_frame();
		end
		drain();

		$display("fed %0d bytes in %0d frames, checked %0d result items",
			bytes_fed, frames_sent, results_checked);
		$display("covered scalars, headers, payloads, long varints, stops and cut frames");
		if (mismatches == 0 && results_due == 0)
			$display("PASS protobuf_wire_stream_parser_top");
		else
			$display("FAIL protobuf_wire_stream_parser_top");
		$finish;
	end

endmodule
